FILE: rtl/kear_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kear_pkg
// shared widths, register map, reset values and types of the key edge and
// auto-repeat core
// ----------------------------------------------------------------------------
package kear_pkg;

    localparam int KEY_W   = 8;
    localparam int GROUP_W = 3;
    localparam int HOLD_W  = 8;

    // apb register map
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    typedef enum logic
    {
        REG_REPEAT_GROUP    = 1'b0,
        REG_REPEAT_KEY_MASK = 1'b1
    } kear_reg_t;

    localparam logic [GROUP_W-1:0] REPEAT_GROUP_RST    = 3'd7;
    localparam logic [KEY_W-1:0]   REPEAT_KEY_MASK_RST = 8'h0F;
    localparam logic [HOLD_W-1:0]  HOLD_MAX            = 8'hFF;

    // per-scan request to the repeat counters
    typedef struct packed
    {
        logic             step;
        logic [KEY_W-1:0] now;
        logic [KEY_W-1:0] prev;
        logic [KEY_W-1:0] key_mask;
    } kear_rpt_req_t;

endpackage

FILE: rtl/kear_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kear_in_if
// scan channel: one group byte and query mask per transfer
// ----------------------------------------------------------------------------
interface kear_in_if;

    logic                          valid;
    logic                          ready;
    logic [kear_pkg::GROUP_W-1:0]  group_index;
    logic [kear_pkg::KEY_W-1:0]    scan_byte;
    logic [kear_pkg::KEY_W-1:0]    key_mask;

    modport source
    (
        output valid,
        output group_index,
        output scan_byte,
        output key_mask,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  group_index,
        input  scan_byte,
        input  key_mask,
        output ready
    );

endinterface

FILE: rtl/kear_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kear_out_if
// result channel: down, pressed and released key bits per transfer
// ----------------------------------------------------------------------------
interface kear_out_if;

    logic                        valid;
    logic                        ready;
    logic [kear_pkg::KEY_W-1:0]  down_bits;
    logic [kear_pkg::KEY_W-1:0]  pressed_bits;
    logic [kear_pkg::KEY_W-1:0]  released_bits;

    modport source
    (
        output valid,
        output down_bits,
        output pressed_bits,
        output released_bits,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  down_bits,
        input  pressed_bits,
        input  released_bits,
        output ready
    );

endinterface

FILE: rtl/kear_repeat.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kear_repeat
// per-key saturating hold counters and repeat phase of the repeat group
// ----------------------------------------------------------------------------
module kear_repeat #(
    parameter int REPEAT_DELAY  = 12,
    parameter int REPEAT_PERIOD = 3
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  kear_pkg::kear_rpt_req_t       req,
    output logic [kear_pkg::KEY_W-1:0]    pulse
);

    localparam int PH_W = (REPEAT_PERIOD > 1) ? $clog2(REPEAT_PERIOD) : 1;
    localparam logic [PH_W-1:0] PH_LAST = PH_W'(REPEAT_PERIOD - 1);
    localparam logic [kear_pkg::HOLD_W-1:0] DELAY_CNT = kear_pkg::HOLD_W'(REPEAT_DELAY);
    // once saturated the count no longer moves, so the pulse is fixed
    localparam logic SAT_PULSE = (((255 - REPEAT_DELAY) % REPEAT_PERIOD) == 0);

    logic [kear_pkg::HOLD_W-1:0] hold_reg  [kear_pkg::KEY_W];
    logic [kear_pkg::HOLD_W-1:0] hold_next [kear_pkg::KEY_W];
    logic [PH_W-1:0]             phase_reg  [kear_pkg::KEY_W];
    logic [PH_W-1:0]             phase_next [kear_pkg::KEY_W];

    genvar b;
    generate
        for (b = 0; b < kear_pkg::KEY_W; b++)
        begin : g_key
            logic                        active;
            logic                        sat;
            logic [kear_pkg::HOLD_W-1:0] hold_inc;
            logic [PH_W-1:0]             phase_step;

            assign active   = req.key_mask[b] & req.now[b] & req.prev[b];
            assign sat      = (hold_reg[b] == kear_pkg::HOLD_MAX);
            assign hold_inc = sat ? hold_reg[b] : hold_reg[b] + 1'b1;

            always_comb
            begin
                if (hold_inc == DELAY_CNT)
                begin
                    phase_step = '0;
                end
                else if (phase_reg[b] == PH_LAST)
                begin
                    phase_step = '0;
                end
                else
                begin
                    phase_step = phase_reg[b] + 1'b1;
                end
            end

            always_comb
            begin
                hold_next[b]  = hold_reg[b];
                phase_next[b] = phase_reg[b];
                pulse[b]      = 1'b0;
                if (req.step)
                begin
                    if (!active)
                    begin
                        hold_next[b]  = '0;
                        phase_next[b] = '0;
                    end
                    else
                    begin
                        hold_next[b] = hold_inc;
                        if (sat)
                        begin
                            pulse[b] = SAT_PULSE;
                        end
                        else
                        begin
                            phase_next[b] = phase_step;
                            pulse[b] = (hold_inc >= DELAY_CNT) && (phase_step == '0);
                        end
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    hold_reg[b]  <= '0;
                    phase_reg[b] <= '0;
                end
                else
                begin
                    hold_reg[b]  <= hold_next[b];
                    phase_reg[b] <= phase_next[b];
                end
            end
        end
    endgenerate

endmodule

FILE: rtl/key_edge_and_auto_repeat_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_edge_and_auto_repeat_core
// key edge detector with typematic auto-repeat for a scanned keypad
// ----------------------------------------------------------------------------
// in_ch carries one keypad group byte with its group number and a query mask
// per transfer; out_ch returns the masked down, pressed and released bits of
// that group, one result per scan, in order.
// an input register feeds one pass of edge and repeat logic into an output
// register, and a result is offered on out_ch once it is in the output
// register; one scan is taken every cycle while out_ch keeps up.
// when out_ch stalls, the output register holds its result and the input
// register takes one more scan before in_ch ready drops.
// the apb port sets the repeat group (offset 0) and repeat key mask
// (offset 4); write them only while no scan is in flight.
// reset clears the stored group bytes, so keys held at reset report as
// pressed on the first scan, clears all hold counters and loads the
// register defaults (group 7, mask 0x0f).
// a group number of 0 or beyond the group count returns all zero bits and
// leaves the state untouched.
// ----------------------------------------------------------------------------
module key_edge_and_auto_repeat_core #(
    parameter int REPEAT_DELAY  = 12,
    parameter int REPEAT_PERIOD = 3,
    parameter int GROUP_COUNT   = 7
) (
    input  logic                          clk,
    input  logic                          rst_n,
    kear_in_if.sink                       in_ch,
    kear_out_if.source                    out_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kear_pkg::ADDR_W-1:0]   paddr,
    input  logic [kear_pkg::DATA_W-1:0]   pwdata,
    output logic [kear_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int IDX_W = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
    localparam int GW    = kear_pkg::GROUP_W;
    localparam int KW    = kear_pkg::KEY_W;

    // configuration
    logic [GW-1:0] repeat_group_reg;
    logic [KW-1:0] repeat_key_mask_reg;
    logic          cfg_write;
    kear_pkg::kear_reg_t cfg_sel;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;
    assign cfg_sel   = kear_pkg::kear_reg_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repeat_group_reg    <= kear_pkg::REPEAT_GROUP_RST;
            repeat_key_mask_reg <= kear_pkg::REPEAT_KEY_MASK_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_sel)
                kear_pkg::REG_REPEAT_GROUP:    repeat_group_reg    <= pwdata[GW-1:0];
                kear_pkg::REG_REPEAT_KEY_MASK: repeat_key_mask_reg <= pwdata[KW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            kear_pkg::REG_REPEAT_GROUP:
                prdata = {{(kear_pkg::DATA_W-GW){1'b0}}, repeat_group_reg};
            kear_pkg::REG_REPEAT_KEY_MASK:
                prdata = {{(kear_pkg::DATA_W-KW){1'b0}}, repeat_key_mask_reg};
            default:
                prdata = '0;
        endcase
    end

    // input register
    logic          in_valid_reg;
    logic [GW-1:0] grp_reg;
    logic [KW-1:0] scan_reg;
    logic [KW-1:0] ask_reg;
    logic          advance;
    logic          load_in;

    // output register
    logic          out_valid_reg;
    logic [KW-1:0] down_reg;
    logic [KW-1:0] pressed_reg;
    logic [KW-1:0] released_reg;

    assign advance     = in_valid_reg & (~out_valid_reg | out_ch.ready);
    assign in_ch.ready = ~in_valid_reg | advance;
    assign load_in     = in_ch.valid & in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (load_in)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_in)
        begin
            grp_reg  <= in_ch.group_index;
            scan_reg <= in_ch.scan_byte;
            ask_reg  <= in_ch.key_mask;
        end
    end

    // previous scan store and edge logic
    logic [KW-1:0]       prev_reg [GROUP_COUNT];
    logic                grp_ok;
    logic [GW-1:0]       grp_m1;
    logic [IDX_W+GW-1:0] grp_wide;
    logic [IDX_W-1:0]    grp_idx;
    logic [KW-1:0]       prev_bits;
    logic [KW-1:0]       pulse;
    logic [KW-1:0]       down_next;
    logic [KW-1:0]       pressed_next;
    logic [KW-1:0]       released_next;
    kear_pkg::kear_rpt_req_t rpt_req;

    assign grp_ok    = (grp_reg != '0) && ({{(32-GW){1'b0}}, grp_reg} <= 32'(GROUP_COUNT));
    assign grp_m1    = grp_reg - 1'b1;
    assign grp_wide  = {{IDX_W{1'b0}}, grp_m1};
    assign grp_idx   = grp_wide[IDX_W-1:0];
    assign prev_bits = grp_ok ? prev_reg[grp_idx] : '0;

    assign rpt_req.step     = advance & grp_ok & (grp_reg == repeat_group_reg);
    assign rpt_req.now      = scan_reg;
    assign rpt_req.prev     = prev_bits;
    assign rpt_req.key_mask = repeat_key_mask_reg;

    kear_repeat #(
        .REPEAT_DELAY  (REPEAT_DELAY),
        .REPEAT_PERIOD (REPEAT_PERIOD)
    ) u_repeat (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rpt_req),
        .pulse (pulse)
    );

    always_comb
    begin
        if (grp_ok)
        begin
            down_next     = scan_reg & ask_reg;
            pressed_next  = ((scan_reg & ~prev_bits) | pulse) & ask_reg;
            released_next = ~scan_reg & prev_bits & ask_reg;
        end
        else
        begin
            down_next     = '0;
            pressed_next  = '0;
            released_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g < GROUP_COUNT; g++)
            begin
                prev_reg[g] <= '0;
            end
        end
        else if (advance && grp_ok)
        begin
            prev_reg[grp_idx] <= scan_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            down_reg     <= down_next;
            pressed_reg  <= pressed_next;
            released_reg <= released_next;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.down_bits     = down_reg;
    assign out_ch.pressed_bits  = pressed_reg;
    assign out_ch.released_bits = released_reg;

endmodule

FILE: rtl/kear_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kear_checker
// port-level checks of the key edge and auto-repeat core
// ----------------------------------------------------------------------------
module kear_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [kear_pkg::KEY_W-1:0]  down_bits,
    input logic [kear_pkg::KEY_W-1:0]  pressed_bits,
    input logic [kear_pkg::KEY_W-1:0]  released_bits
);

    // a stalled result stays offered
    a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // a key cannot be down and released in the same scan
    a_down_released : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((down_bits & released_bits) == '0))
        else $error("key both down and released");

    // presses and repeat pulses only come from keys that are down
    a_pressed_down : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((pressed_bits & ~down_bits) == '0))
        else $error("pressed key not down");

    // a fresh result follows a scan transfer through the input and output registers
    a_latency : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without matching scan transfer");

endmodule

bind key_edge_and_auto_repeat_core kear_checker u_kear_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .down_bits     (out_ch.down_bits),
    .pressed_bits  (out_ch.pressed_bits),
    .released_bits (out_ch.released_bits)
);

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the key edge and auto-repeat core
// ----------------------------------------------------------------------------
// scans go in through the input channel and results come back on the output
// channel. every accepted scan is run through a local model of the previous
// group bytes, the repeat hold counters and the apb registers. that gives the
// expected down, pressed and released bits, and they are queued in order.
// each result transfer is checked field by field against the oldest entry.
// the tests cover directed edges, invalid groups and key repeat timing.
// they run under several register settings, counter saturation and a long
// output stall, with random gaps on both channels.
// ----------------------------------------------------------------------------
module testbench;

    localparam int KEY_W   = kear_pkg::KEY_W;
    localparam int GROUP_W = kear_pkg::GROUP_W;
    localparam int HOLD_W  = kear_pkg::HOLD_W;
    localparam int ADDR_W  = kear_pkg::ADDR_W;
    localparam int DATA_W  = kear_pkg::DATA_W;

    localparam int REPEAT_DELAY  = 12;
    localparam int REPEAT_PERIOD = 3;
    localparam int GROUP_COUNT   = 7;

    typedef struct packed
    {
        logic [KEY_W-1:0] down;
        logic [KEY_W-1:0] pressed;
        logic [KEY_W-1:0] released;
    } key_report_t;

    typedef enum int
    {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    kear_in_if  in_ch ();
    kear_out_if out_ch ();

    key_edge_and_auto_repeat_core #(
        .REPEAT_DELAY  (REPEAT_DELAY),
        .REPEAT_PERIOD (REPEAT_PERIOD),
        .GROUP_COUNT   (GROUP_COUNT)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // model state
    logic [KEY_W-1:0]   last_scan [1:GROUP_COUNT];
    logic [HOLD_W-1:0]  hold_frames [KEY_W];
    logic [GROUP_W-1:0] cfg_repeat_group;
    logic [KEY_W-1:0]   cfg_repeat_keys;

    key_report_t        expected_reports [$];
    logic [KEY_W-1:0]   key_pattern [8];
    int                 mismatch_count;
    int                 send_idle_pct;
    int                 recv_stall_pct;
    int                 hold_off_left;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("** key_edge_and_auto_repeat_core: FAILED **");
        $finish;
    end

    function automatic key_report_t predict_scan(input logic [GROUP_W-1:0] grp,
                                                 input logic [KEY_W-1:0] now,
                                                 input logic [KEY_W-1:0] ask);
        key_report_t      rpt;
        logic [KEY_W-1:0] prev_bits;
        logic [KEY_W-1:0] pulse;
        int               held;
        rpt   = '0;
        pulse = '0;
        if (grp == 0 || grp > GROUP_COUNT)
            return rpt;
        prev_bits = last_scan[grp];
        if (grp == cfg_repeat_group)
        begin
            for (int k = 0; k < KEY_W; k++)
            begin
                if (!cfg_repeat_keys[k] || !now[k] || !prev_bits[k])
                    hold_frames[k] = '0;
                else
                begin
                    if (hold_frames[k] != kear_pkg::HOLD_MAX)
                        hold_frames[k] = hold_frames[k] + 1'b1;
                    held = int'(hold_frames[k]);
                    if (held == REPEAT_DELAY ||
                        (held > REPEAT_DELAY && (held - REPEAT_DELAY) % REPEAT_PERIOD == 0))
                        pulse[k] = 1'b1;
                end
            end
        end
        rpt.down     = now & ask;
        rpt.pressed  = ((now & ~prev_bits) | pulse) & ask;
        rpt.released = ~now & prev_bits & ask;
        last_scan[grp] = now;
        return rpt;
    endfunction

    function automatic void note_mismatch(input string what, input logic [DATA_W-1:0] want,
                                          input logic [DATA_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
    endfunction

    // scan transfers into the model
    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
            expected_reports.push_back(predict_scan(in_ch.group_index, in_ch.scan_byte,
                                                    in_ch.key_mask));
    end

    // result transfers against the model
    always @(posedge clk)
    begin
        key_report_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_reports.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t result with nothing expected", $realtime);
            end
            else
            begin
                want = expected_reports.pop_front();
                if (out_ch.down_bits !== want.down)
                    note_mismatch("down_bits", DATA_W'(want.down),
                                  DATA_W'(out_ch.down_bits));
                if (out_ch.pressed_bits !== want.pressed)
                    note_mismatch("pressed_bits", DATA_W'(want.pressed),
                                  DATA_W'(out_ch.pressed_bits));
                if (out_ch.released_bits !== want.released)
                    note_mismatch("released_bits", DATA_W'(want.released),
                                  DATA_W'(out_ch.released_bits));
            end
        end
    end

    // receiver with random stalls and an optional long hold-off
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_left > 0)
            begin
                out_ch.ready <= 1'b0;
                hold_off_left--;
            end
            else
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic set_idle(input idle_mode_t mode);
        case (mode)
            IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 77; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 77; end
            default:       begin send_idle_pct = 24; recv_stall_pct = 24; end
        endcase
    endtask

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_scan(input logic [GROUP_W-1:0] grp, input logic [KEY_W-1:0] scan,
                             input logic [KEY_W-1:0] ask);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid       <= 1'b0;
            in_ch.group_index <= GROUP_W'($urandom);
            in_ch.scan_byte   <= KEY_W'($urandom);
            in_ch.key_mask    <= KEY_W'($urandom);
            @(negedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.group_index <= grp;
        in_ch.scan_byte   <= scan;
        in_ch.key_mask    <= ask;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(negedge clk);
        while (expected_reports.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic apb_access(input logic wr, input kear_pkg::kear_reg_t idx,
                              input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_reg(input kear_pkg::kear_reg_t idx, input logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] rdata;
        logic [DATA_W-1:0] want;
        apb_access(1'b1, idx, value, rdata);
        case (idx)
            kear_pkg::REG_REPEAT_GROUP:    cfg_repeat_group = value[GROUP_W-1:0];
            kear_pkg::REG_REPEAT_KEY_MASK: cfg_repeat_keys  = value[KEY_W-1:0];
        endcase
        apb_access(1'b0, idx, '0, rdata);
        want = (idx == kear_pkg::REG_REPEAT_GROUP) ? DATA_W'(cfg_repeat_group)
                                                   : DATA_W'(cfg_repeat_keys);
        if (rdata !== want)
            note_mismatch("register read", want, rdata);
    endtask

    // held keys mostly persist, so hold counters get to run
    task automatic random_scans(input int count);
        logic [GROUP_W-1:0] grp;
        logic [KEY_W-1:0]   scan;
        logic [KEY_W-1:0]   ask;
        logic [KEY_W-1:0]   flips;
        int                 roll;
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(99);
            if (roll < 5)
                grp = '0;
            else if (roll < 60 && cfg_repeat_group != 0)
                grp = cfg_repeat_group;
            else
                grp = GROUP_W'($urandom_range(GROUP_COUNT, 1));
            if (grp == cfg_repeat_group)
                flips = KEY_W'($urandom & $urandom & $urandom & $urandom);
            else
                flips = KEY_W'($urandom & $urandom);
            if ($urandom_range(9) == 0)
                scan = KEY_W'($urandom);
            else
                scan = key_pattern[grp] ^ flips;
            key_pattern[grp] = scan;
            ask = ($urandom_range(9) < 7) ? 8'hFF : KEY_W'($urandom);
            send_scan(grp, scan, ask);
        end
    endtask

    task automatic test_first_scan_directed();
        set_idle(IDLE_NONE);
        send_scan(3'd1, 8'hFF, 8'hFF);
        send_scan(3'd1, 8'hFF, 8'hFF);
        send_scan(3'd1, 8'h00, 8'hFF);
        send_scan(3'd0, 8'hFF, 8'hFF);
        send_scan(3'd7, 8'h0F, 8'hFF);
        send_scan(3'd7, 8'hFF, 8'h00);
        send_scan(3'd7, 8'hF0, 8'hFF);
        send_scan(3'd2, 8'hAA, 8'h55);
        send_scan(3'd2, 8'h55, 8'hFF);
        send_scan(3'd3, 8'h80, 8'h80);
        send_scan(3'd4, 8'h01, 8'h01);
        send_scan(3'd5, 8'hFF, 8'h0F);
        send_scan(3'd6, 8'hFF, 8'hF0);
        send_scan(3'd6, 8'h00, 8'hFF);
        send_scan(3'd0, 8'h00, 8'h00);
        send_scan(3'd7, 8'h00, 8'hFF);
    endtask

    task automatic test_auto_repeat();
        set_idle(IDLE_SENDER);
        for (int n = 0; n < 20; n++)
        begin
            send_scan(3'd7, 8'h3C, 8'hFF);
            send_scan(GROUP_W'($urandom_range(6, 1)), KEY_W'($urandom), 8'hFF);
        end
        send_scan(3'd7, 8'h38, 8'hFF);
        send_scan(3'd7, 8'h3C, 8'hFF);
    endtask

    task automatic test_register_settings();
        logic [GROUP_W-1:0] grp;
        logic [KEY_W-1:0]   keys;
        for (int phase = 0; phase < 7; phase++)
        begin
            case (phase)
                0:       begin grp = 3'd1; keys = 8'hFF; end
                1:       begin grp = 3'd0; keys = 8'hFF; end
                2:       begin grp = 3'd4; keys = 8'h00; end
                3:       begin grp = 3'd3; keys = KEY_W'($urandom); end
                4:       begin grp = 3'd7; keys = 8'h80; end
                5:       begin grp = 3'd2; keys = 8'h01; end
                default: begin grp = GROUP_W'($urandom_range(GROUP_COUNT, 1));
                               keys = KEY_W'($urandom); end
            endcase
            drain_results();
            write_reg(kear_pkg::REG_REPEAT_GROUP, DATA_W'(grp));
            write_reg(kear_pkg::REG_REPEAT_KEY_MASK, DATA_W'(keys));
            set_idle(idle_mode_t'(phase % 4));
            random_scans(60);
        end
    endtask

    task automatic test_hold_saturation();
        drain_results();
        write_reg(kear_pkg::REG_REPEAT_GROUP, 32'd5);
        write_reg(kear_pkg::REG_REPEAT_KEY_MASK, 32'h81);
        set_idle(IDLE_NONE);
        for (int n = 0; n < 330; n++)
        begin
            if (n % 8 == 7)
                send_scan(GROUP_W'($urandom_range(4, 1)), KEY_W'($urandom), 8'hFF);
            else
                send_scan(3'd5, 8'h81 | (KEY_W'($urandom) & 8'h7E),
                          $urandom_range(1) ? 8'hFF : KEY_W'($urandom));
        end
        send_scan(3'd5, 8'h00, 8'hFF);
    endtask

    task automatic test_output_backpressure();
        set_idle(IDLE_NONE);
        hold_off_left = 60;
        random_scans(30);
    endtask

    initial
    begin
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        in_ch.valid       = 1'b0;
        in_ch.group_index = '0;
        in_ch.scan_byte   = '0;
        in_ch.key_mask    = '0;
        mismatch_count    = 0;
        hold_off_left     = 0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        cfg_repeat_group  = kear_pkg::REPEAT_GROUP_RST;
        cfg_repeat_keys   = kear_pkg::REPEAT_KEY_MASK_RST;
        for (int g = 1; g <= GROUP_COUNT; g++)
            last_scan[g] = '0;
        for (int k = 0; k < KEY_W; k++)
            hold_frames[k] = '0;
        for (int g = 0; g < 8; g++)
            key_pattern[g] = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_first_scan_directed();
        test_auto_repeat();
        test_register_settings();
        test_hold_saturation();
        test_output_backpressure();

        drain_results();
        repeat (8) @(negedge clk);
        if (mismatch_count == 0 && expected_reports.size() == 0)
            $display("** key_edge_and_auto_repeat_core: PASSED **");
        else
            $display("** key_edge_and_auto_repeat_core: FAILED **");
        $finish;
    end

endmodule

FILE: sim.f
rtl/kear_pkg.sv
rtl/kear_in_if.sv
rtl/kear_out_if.sv
rtl/kear_repeat.sv
rtl/key_edge_and_auto_repeat_core.sv
rtl/kear_checker.sv
dv/testbench.sv
